// ===== hdl/mvt_pkg.sv =====
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants for the matrix vector transform
// Payload structs, register map, fixed-point format and pipeline controls.
// ----------------------------------------------------------------------------
package mvt_pkg;

   // fixed-point format of entries, inputs and results
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;      // one entry times one component
   localparam int PAIR_W    = PROD_W + 1;      // sum of two products
   localparam int SUM_W     = PROD_W + 2;      // sum of four products, exact
   localparam int SHIFT_W   = SUM_W - FRAC_BITS; // exact sum after the shift

   // register map: eight 64-bit registers at byte address 8*i
   localparam int NUM_REGS  = 8;
   localparam int REG_W     = 64;
   localparam int IDX_W     = $clog2(NUM_REGS);
   localparam int ADDR_W    = IDX_W + 3;
   localparam int NUM_ENTRY = 2 * NUM_REGS;
   localparam int ROW_LEN   = 4;

   // 1.0 in the entry format, and the identity matrix at reset
   localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;
   localparam logic [REG_W-1:0] ONE_LO = {{DATA_W{1'b0}}, ONE};
   localparam logic [REG_W-1:0] ONE_HI = {ONE, {DATA_W{1'b0}}};
   localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
      ONE_LO, '0, ONE_HI, '0, '0, ONE_LO, '0, ONE_HI
   };

   // saturation limits
   localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic signed [DATA_W-1:0] in_x;
      logic signed [DATA_W-1:0] in_y;
      logic signed [DATA_W-1:0] in_z;
      logic signed [DATA_W-1:0] in_w;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_x;
      logic signed [DATA_W-1:0] out_y;
      logic signed [DATA_W-1:0] out_z;
      logic signed [DATA_W-1:0] out_w;
      logic                     overflow;
   } rsp_payload_type;

   // per-stage load enables from the pipeline control
   typedef struct packed {
      logic load_mul;
      logic load_pair;
      logic load_out;
   } pipe_ctl_type;

endpackage

// ===== hdl/mvt_csr.sv =====
// ----------------------------------------------------------------------------
// mvt_csr: matrix register file
// Eight 64-bit APB registers, two Q16.16 entries each, identity at reset.
// ----------------------------------------------------------------------------
module mvt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mvt_pkg::ADDR_W-1:0]          paddr,
   input  logic [mvt_pkg::REG_W-1:0]           pwdata,
   output logic [mvt_pkg::REG_W-1:0]           prdata,
   output logic                                pready,
   output logic [mvt_pkg::NUM_ENTRY-1:0][mvt_pkg::DATA_W-1:0] entries
);

   logic [mvt_pkg::REG_W-1:0] reg_ff [mvt_pkg::NUM_REGS];
   logic [mvt_pkg::IDX_W-1:0] reg_idx;
   logic                      wr_en;

   // word index from the byte address; low three bits select bytes only
   assign reg_idx = paddr[mvt_pkg::ADDR_W-1:3];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign prdata  = reg_ff[reg_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mvt_pkg::NUM_REGS; i++) begin
            reg_ff[i] <= mvt_pkg::REG_RESET[i];
         end
      end else if (wr_en) begin
         reg_ff[reg_idx] <= pwdata;
      end
   end

   // lower-index entry in the low half
   always_comb begin
      for (int i = 0; i < mvt_pkg::NUM_REGS; i++) begin
         entries[2*i]   = reg_ff[i][mvt_pkg::DATA_W-1:0];
         entries[2*i+1] = reg_ff[i][mvt_pkg::REG_W-1:mvt_pkg::DATA_W];
      end
   end

endmodule

// ===== hdl/mvt_dot.sv =====
// ----------------------------------------------------------------------------
// mvt_dot: one row dot product, three register stages
// Four multipliers, a pair-add stage, then final add, shift and saturate.
// ----------------------------------------------------------------------------
module mvt_dot (
   input  logic                                          clock,
   input  mvt_pkg::pipe_ctl_type                         ctl,
   input  logic [mvt_pkg::ROW_LEN-1:0][mvt_pkg::DATA_W-1:0] row,
   input  mvt_pkg::req_payload_type                      vec,
   output logic signed [mvt_pkg::DATA_W-1:0]             result,
   output logic                                          sat
);

   logic signed [mvt_pkg::DATA_W-1:0] comp [mvt_pkg::ROW_LEN];
   logic signed [mvt_pkg::PROD_W-1:0] prod_in [mvt_pkg::ROW_LEN];
   logic signed [mvt_pkg::PROD_W-1:0] prod_ff [mvt_pkg::ROW_LEN];
   logic signed [mvt_pkg::PAIR_W-1:0] pair_in [2];
   logic signed [mvt_pkg::PAIR_W-1:0] pair_ff [2];
   logic signed [mvt_pkg::SUM_W-1:0]  sum;
   logic signed [mvt_pkg::SHIFT_W-1:0] shifted;
   logic                              fits;
   logic signed [mvt_pkg::DATA_W-1:0] result_in;
   logic signed [mvt_pkg::DATA_W-1:0] result_ff;
   logic                              sat_in;
   logic                              sat_ff;

   assign comp[0] = vec.in_x;
   assign comp[1] = vec.in_y;
   assign comp[2] = vec.in_z;
   assign comp[3] = vec.in_w;

   // stage 1: one 32x32 signed multiply per column
   always_comb begin
      for (int j = 0; j < mvt_pkg::ROW_LEN; j++) begin
         prod_in[j] = $signed(row[j]) * comp[j];
      end
   end

   // stage 2: pairwise sums, sign-extended
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         pair_in[k] = mvt_pkg::PAIR_W'(prod_ff[2*k]) + mvt_pkg::PAIR_W'(prod_ff[2*k+1]);
      end
   end

   // stage 3: exact final sum, arithmetic shift, saturation
   always_comb begin
      sum     = mvt_pkg::SUM_W'(pair_ff[0]) + mvt_pkg::SUM_W'(pair_ff[1]);
      shifted = mvt_pkg::SHIFT_W'(sum >>> mvt_pkg::FRAC_BITS);
      // in range when every bit from the result sign up matches
      fits    = (shifted[mvt_pkg::SHIFT_W-1:mvt_pkg::DATA_W-1] == '0) ||
                (shifted[mvt_pkg::SHIFT_W-1:mvt_pkg::DATA_W-1] == '1);
      sat_in  = !fits;
      if (fits) begin
         result_in = shifted[mvt_pkg::DATA_W-1:0];
      end else if (sum[mvt_pkg::SUM_W-1]) begin
         result_in = mvt_pkg::SAT_NEG;
      end else begin
         result_in = mvt_pkg::SAT_POS;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_mul) begin
         prod_ff <= prod_in;
      end
      if (ctl.load_pair) begin
         pair_ff <= pair_in;
      end
      if (ctl.load_out) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign result = result_ff;
   assign sat    = sat_ff;

endmodule

// ===== hdl/matrix_vector_transform.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_transform: 4x4 Q16.16 matrix times 4-vector
// Pipelined vertex transform with saturating outputs and an overflow flag.
// ----------------------------------------------------------------------------
//
//   channel   ports                    direction  payload
//   req       req_valid/req_stall      in         in_x, in_y, in_z, in_w
//   rsp       rsp_valid/rsp_stall      out        out_x..out_w, overflow
//   csr       csr_psel..csr_pready     in         8 x 64-bit matrix registers
//
// One vector per cycle sustained while rsp_stall is low; the pipeline registers
// multiply, pair add, and final add with saturation, in that order.
// Synchronous reset empties the pipeline and loads the identity matrix.
// A stalled result holds in the last stage; upstream stages keep filling
// until full, so req_stall rises only with all stages occupied.
// ----------------------------------------------------------------------------
module matrix_vector_transform (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  mvt_pkg::req_payload_type         req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output mvt_pkg::rsp_payload_type         rsp_payload,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mvt_pkg::ADDR_W-1:0]       csr_paddr,
   input  logic [mvt_pkg::REG_W-1:0]        csr_pwdata,
   output logic [mvt_pkg::REG_W-1:0]        csr_prdata,
   output logic                             csr_pready
);

   logic [mvt_pkg::NUM_ENTRY-1:0][mvt_pkg::DATA_W-1:0] entries;
   mvt_pkg::pipe_ctl_type ctl;
   logic [3:0] sat;
   logic signed [mvt_pkg::DATA_W-1:0] result [4];
   logic valid_mul_ff, valid_pair_ff, valid_out_ff;
   logic ready_mul, ready_pair, ready_out;

   mvt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .entries (entries)
   );

   // a stage takes new data when empty or when its content moves on
   assign ready_out  = !valid_out_ff || !rsp_stall;
   assign ready_pair = !valid_pair_ff || ready_out;
   assign ready_mul  = !valid_mul_ff || ready_pair;
   assign req_stall  = !ready_mul;

   assign ctl.load_mul  = req_valid && ready_mul;
   assign ctl.load_pair = valid_mul_ff && ready_pair;
   assign ctl.load_out  = valid_pair_ff && ready_out;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_mul_ff  <= 1'b0;
         valid_pair_ff <= 1'b0;
         valid_out_ff  <= 1'b0;
      end else begin
         if (ready_mul) begin
            valid_mul_ff <= req_valid;
         end
         if (ready_pair) begin
            valid_pair_ff <= valid_mul_ff;
         end
         if (ready_out) begin
            valid_out_ff <= valid_pair_ff;
         end
      end
   end

   // one dot-product lane per matrix row
   for (genvar i = 0; i < 4; i++) begin : g_row
      mvt_dot u_dot (
         .clock  (clock),
         .ctl    (ctl),
         .row    (entries[mvt_pkg::ROW_LEN*i +: mvt_pkg::ROW_LEN]),
         .vec    (req_payload),
         .result (result[i]),
         .sat    (sat[i])
      );
   end

   assign rsp_valid            = valid_out_ff;
   assign rsp_payload.out_x    = result[0];
   assign rsp_payload.out_y    = result[1];
   assign rsp_payload.out_z    = result[2];
   assign rsp_payload.out_w    = result[3];
   assign rsp_payload.overflow = |sat;

`ifndef SYNTHESIS
   // input backpressure only when the output itself is stalled
   a_stall_from_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_stall && valid_mul_ff && valid_pair_ff && valid_out_ff))
      else $error("req_stall without a full, stalled pipeline");

   // an accepted transaction reaches the output when rsp_stall stays low as it passes the pair and output stages
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("transaction did not reach the output stage");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !valid_mul_ff && !valid_pair_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule
